[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

[sv/rsi_pkg.sv]
// ----------------------------------------------------------------------------
// RSI package
// Shared types and constants of the relative strength index block.
// ----------------------------------------------------------------------------
package rsi_pkg;

   // Port field widths
   localparam int FIELD_BITS  = 32;
   localparam int WLEN_BITS   = 7;
   localparam int RSI_BITS    = 23;
   localparam int STATUS_BITS = 2;

   localparam logic [WLEN_BITS-1:0] WLEN_RESET = 7'd14;

   // 100 percent in Q.16: 6553600 = 25 << 18
   localparam logic [RSI_BITS-1:0] RSI_FULL = 23'd6553600;
   localparam int SCALE_SHIFT  = 18;
   localparam int DIV_STEPS    = 23;
   localparam int PRE_SHIFT    = DIV_STEPS - SCALE_SHIFT;
   localparam int DIV_CNT_BITS = 5;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = 2;
   localparam int QCNT_BITS   = 3;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_WARMING = 2'd0,
      ST_OK      = 2'd1,
      ST_UNDEF   = 2'd2
   } rsi_status_type;

   typedef enum logic {
      FR_IDLE,
      FR_UPDATE
   } rsi_front_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_PREP,
      BK_DIVIDE,
      BK_FINISH
   } rsi_back_state_type;

   typedef struct packed {
      logic empty;
      logic full;
   } rsi_qstat_type;

endpackage

[sv/relative_strength_index.sv]
// ----------------------------------------------------------------------------
// Relative strength index
// Simple-average RSI over a programmable window of price bars.
// ----------------------------------------------------------------------------
// Each input item is one bar (open, close); each bar gives exactly one result
// item with RSI = 100 * G / (G + L) in Q.16 percent, rounded half up, plus a
// status (warming, valid, undefined when both sums are zero). The front takes
// a bar only while idle and the queue is not full, updating the ring windows
// and running sums, and hands the sums through a 4-entry queue to the back.
// The back runs its 23-step restoring divider (one quotient bit per cycle) for
// a valid result and skips it for a warming or undefined one; it pops the next
// sums only once the last result has gone to the output register. Writing
// csr_wdata empties the window at once; write it only while no bar is in
// flight. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module relative_strength_index import rsi_pkg::*; #(
   parameter int MAX_WINDOW = 64,
   parameter int PRICE_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [FIELD_BITS-1:0]  req_open_price,
   input  logic [FIELD_BITS-1:0]  req_close_price,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [RSI_BITS-1:0]    rsp_rsi_value,
   output logic [STATUS_BITS-1:0] rsp_status,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [WLEN_BITS-1:0]   csr_wdata
);

   localparam int SLOT_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int SUM_BITS  = PRICE_BITS + SLOT_BITS;

   rsi_qstat_type       q_stat;
   logic                q_push, q_pop;
   logic [2*SUM_BITS:0] q_wdata, q_rdata;

   rsi_front #(
      .MAX_WINDOW (MAX_WINDOW),
      .PRICE_BITS (PRICE_BITS),
      .SLOT_BITS  (SLOT_BITS),
      .SUM_BITS   (SUM_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_open_price  (req_open_price),
      .req_close_price (req_close_price),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata),
      .q_stat          (q_stat),
      .q_push          (q_push),
      .q_data          (q_wdata)
   );

   rsi_queue #(
      .WIDTH (2*SUM_BITS + 1)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .stat  (q_stat)
   );

   rsi_back #(
      .SUM_BITS (SUM_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_stat        (q_stat),
      .q_pop         (q_pop),
      .q_data        (q_rdata),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_rsi_value (rsp_rsi_value),
      .rsp_status    (rsp_status)
   );

endmodule

[sv/rsi_queue.sv]
// ----------------------------------------------------------------------------
// RSI queue
// Short FIFO holding window sums between the front and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsi_queue import rsi_pkg::*; #(
   parameter int WIDTH = 77
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [WIDTH-1:0]   wdata,
   input  logic               pop,
   output logic [WIDTH-1:0]   rdata,
   output rsi_qstat_type      stat
);

   logic [WIDTH-1:0]     entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign do_push = push && (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign do_pop  = pop && (count_ff != '0);

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign rdata      = entry_ff[rd_ptr_ff];
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));

   `ASSERT_NEVER(a_push_when_full, clock, reset, push && stat.full, "queue push while full")

endmodule

[sv/rsi_front.sv]
// ----------------------------------------------------------------------------
// RSI front
// Takes price bars, splits gain and loss, keeps the ring windows and sums.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsi_front import rsi_pkg::*; #(
   parameter int MAX_WINDOW = 64,
   parameter int PRICE_BITS = 32,
   parameter int SLOT_BITS  = 6,
   parameter int SUM_BITS   = 38
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [FIELD_BITS-1:0] req_open_price,
   input  logic [FIELD_BITS-1:0] req_close_price,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [WLEN_BITS-1:0]  csr_wdata,
   input  rsi_qstat_type         q_stat,
   output logic                  q_push,
   output logic [2*SUM_BITS:0]   q_data
);

   localparam int USE_BITS = (PRICE_BITS < FIELD_BITS) ? PRICE_BITS : FIELD_BITS;
   localparam int CMP_BITS = ((SLOT_BITS > WLEN_BITS) ? SLOT_BITS : WLEN_BITS) + 1;

   rsi_front_state_type   state_ff, state_in;
   logic [WLEN_BITS-1:0]  wlen_ff, wlen_in, wlen_clamp;
   logic [WLEN_BITS-1:0]  fill_ff, fill_in;
   logic [SLOT_BITS-1:0]  slot_ff, slot_in;
   logic [SUM_BITS-1:0]   gsum_ff, gsum_in;
   logic [SUM_BITS-1:0]   lsum_ff, lsum_in;

   logic [PRICE_BITS-1:0] gain_ring [MAX_WINDOW];
   logic [PRICE_BITS-1:0] loss_ring [MAX_WINDOW];
   logic [PRICE_BITS-1:0] gain_ff, loss_ff, gain_in, loss_in;
   logic [PRICE_BITS-1:0] gain_old_ff, loss_old_ff;

   logic [PRICE_BITS-1:0] open_p, close_p;
   logic                  accept, ring_we, win_full, warm;
   logic [CMP_BITS-1:0]   slot_next;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == FR_IDLE) && !q_stat.full;
   assign csr_ready = 1'b1;

   // gain and loss of the incoming bar
   always_comb begin
      open_p  = PRICE_BITS'(req_open_price[USE_BITS-1:0]);
      close_p = PRICE_BITS'(req_close_price[USE_BITS-1:0]);
      if (close_p > open_p) begin
         gain_in = close_p - open_p;
         loss_in = '0;
      end else begin
         gain_in = '0;
         loss_in = open_p - close_p;
      end
   end

   // window length clamp: zero means one, large means the ring depth
   always_comb begin
      if (csr_wdata == '0) begin
         wlen_clamp = WLEN_BITS'(1);
      end else if (int'(csr_wdata) > MAX_WINDOW) begin
         wlen_clamp = WLEN_BITS'(MAX_WINDOW);
      end else begin
         wlen_clamp = csr_wdata;
      end
   end

   assign win_full  = (fill_ff == wlen_ff);
   assign warm      = !win_full && ((fill_ff + 1'b1) < wlen_ff);
   assign slot_next = CMP_BITS'(slot_ff) + 1'b1;
   assign q_data    = {warm, gsum_in, lsum_in};

   // sequencer and window bookkeeping
   always_comb begin
      state_in = state_ff;
      wlen_in  = wlen_ff;
      fill_in  = fill_ff;
      slot_in  = slot_ff;
      gsum_in  = gsum_ff;
      lsum_in  = lsum_ff;
      ring_we  = 1'b0;
      q_push   = 1'b0;
      case (state_ff)
         FR_IDLE: begin
            if (accept) begin
               state_in = FR_UPDATE;
            end
         end
         FR_UPDATE: begin
            ring_we  = 1'b1;
            q_push   = 1'b1;
            state_in = FR_IDLE;
            if (win_full) begin
               gsum_in = gsum_ff - SUM_BITS'(gain_old_ff) + SUM_BITS'(gain_ff);
               lsum_in = lsum_ff - SUM_BITS'(loss_old_ff) + SUM_BITS'(loss_ff);
            end else begin
               fill_in = fill_ff + 1'b1;
               gsum_in = gsum_ff + SUM_BITS'(gain_ff);
               lsum_in = lsum_ff + SUM_BITS'(loss_ff);
            end
            if (slot_next >= CMP_BITS'(wlen_ff)) begin
               slot_in = '0;
            end else begin
               slot_in = SLOT_BITS'(slot_next);
            end
         end
         default: begin
            state_in = FR_IDLE;
         end
      endcase
      // a length write empties the window
      if (csr_valid) begin
         wlen_in = wlen_clamp;
         fill_in = '0;
         slot_in = '0;
         gsum_in = '0;
         lsum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
         wlen_ff  <= WLEN_RESET;
         fill_ff  <= '0;
         slot_ff  <= '0;
         gsum_ff  <= '0;
         lsum_ff  <= '0;
      end else begin
         state_ff <= state_in;
         wlen_ff  <= wlen_in;
         fill_ff  <= fill_in;
         slot_ff  <= slot_in;
         gsum_ff  <= gsum_in;
         lsum_ff  <= lsum_in;
      end
   end

   // ring windows: read the leaving entry on accept, write the new one after
   always_ff @(posedge clock) begin
      if (accept) begin
         gain_ff     <= gain_in;
         loss_ff     <= loss_in;
         gain_old_ff <= gain_ring[slot_ff];
         loss_old_ff <= loss_ring[slot_ff];
      end
      if (ring_we) begin
         gain_ring[slot_ff] <= gain_ff;
         loss_ring[slot_ff] <= loss_ff;
      end
   end

   `ASSERT_CLK(a_fill_in_window, clock, reset, fill_ff <= wlen_ff, "fill count above window")
   `ASSERT_CLK(a_slot_in_window, clock, reset, CMP_BITS'(slot_ff) < CMP_BITS'(wlen_ff), "slot out of window")

endmodule

[sv/rsi_back.sv]
// ----------------------------------------------------------------------------
// RSI back
// Scales and divides the window sums into a rounded Q.16 percentage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsi_back import rsi_pkg::*; #(
   parameter int SUM_BITS = 38
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rsi_qstat_type          q_stat,
   output logic                   q_pop,
   input  logic [2*SUM_BITS:0]    q_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [RSI_BITS-1:0]    rsp_rsi_value,
   output logic [STATUS_BITS-1:0] rsp_status
);

   rsi_back_state_type      state_ff, state_in;
   logic [SUM_BITS-1:0]     g_ff, g_in, l_ff, l_in;
   logic                    warm_ff, warm_in;
   logic [SUM_BITS-1:0]     t_ff, t_in, rem_ff, rem_in;
   logic [DIV_STEPS-1:0]    nbits_ff, nbits_in;
   logic [RSI_BITS-1:0]     q_ff, q_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   rsi_status_type          st_ff, st_in;

   logic                    rsp_valid_ff;
   logic [RSI_BITS-1:0]     rsp_rsi_ff;
   logic [STATUS_BITS-1:0]  rsp_status_ff;

   logic [SUM_BITS+4:0]     g25;
   logic [SUM_BITS:0]       rem2, t_ext;
   logic                    ge, round_up, load_out;
   logic [RSI_BITS:0]       q_rnd;
   logic [RSI_BITS-1:0]     rsi_fin;

   // 25 * G: the numerator is this shifted up by 18
   assign g25   = (SUM_BITS+5)'({g_ff, 4'b0}) + (SUM_BITS+5)'({g_ff, 3'b0})
                + (SUM_BITS+5)'(g_ff);
   assign t_ext = {1'b0, t_ff};
   assign rem2  = {rem_ff, nbits_ff[DIV_STEPS-1]};
   assign ge    = (rem2 >= t_ext);

   // round half up, then clamp to full scale
   assign round_up = ({rem_ff, 1'b0} >= t_ext);
   assign q_rnd    = {1'b0, q_ff} + (RSI_BITS+1)'(round_up);
   assign rsi_fin  = (q_rnd > (RSI_BITS+1)'(RSI_FULL)) ? RSI_FULL : q_rnd[RSI_BITS-1:0];

   // sequencer and restoring divider, one quotient bit a cycle
   always_comb begin
      state_in = state_ff;
      g_in     = g_ff;
      l_in     = l_ff;
      warm_in  = warm_ff;
      t_in     = t_ff;
      rem_in   = rem_ff;
      nbits_in = nbits_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      st_in    = st_ff;
      q_pop    = 1'b0;
      load_out = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!q_stat.empty) begin
               q_pop    = 1'b1;
               warm_in  = q_data[2*SUM_BITS];
               g_in     = q_data[2*SUM_BITS-1:SUM_BITS];
               l_in     = q_data[SUM_BITS-1:0];
               state_in = BK_PREP;
            end
         end
         BK_PREP: begin
            t_in     = g_ff + l_ff;
            rem_in   = g25[SUM_BITS+4:PRE_SHIFT];
            nbits_in = {g25[PRE_SHIFT-1:0], {SCALE_SHIFT{1'b0}}};
            q_in     = '0;
            cnt_in   = '0;
            if (warm_ff) begin
               st_in = ST_WARMING;
            end else if ((g_ff == '0) && (l_ff == '0)) begin
               st_in = ST_UNDEF;
            end else begin
               st_in = ST_OK;
            end
            state_in = (st_in == ST_OK) ? BK_DIVIDE : BK_FINISH;
         end
         BK_DIVIDE: begin
            rem_in   = ge ? SUM_BITS'(rem2 - t_ext) : SUM_BITS'(rem2);
            q_in     = {q_ff[RSI_BITS-2:0], ge};
            nbits_in = {nbits_ff[DIV_STEPS-2:0], 1'b0};
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
               state_in = BK_FINISH;
            end
         end
         BK_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath and output item
   always_ff @(posedge clock) begin
      g_ff     <= g_in;
      l_ff     <= l_in;
      warm_ff  <= warm_in;
      t_ff     <= t_in;
      rem_ff   <= rem_in;
      nbits_ff <= nbits_in;
      q_ff     <= q_in;
      cnt_ff   <= cnt_in;
      st_ff    <= st_in;
      if (load_out) begin
         rsp_rsi_ff    <= (st_ff == ST_OK) ? rsi_fin : '0;
         rsp_status_ff <= st_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rsi_value = rsp_rsi_ff;
   assign rsp_status    = rsp_status_ff;

   `ASSERT_CLK(a_rsi_in_range, clock, reset, rsp_valid_ff |-> (rsp_rsi_ff <= RSI_FULL), "rsi above full scale")
   `ASSERT_CLK(a_zero_unless_ok, clock, reset, (rsp_valid_ff && (rsp_status_ff != ST_OK)) |-> (rsp_rsi_ff == '0), "nonzero rsi without valid status")
   `ASSERT_NEVER(a_pop_when_empty, clock, reset, q_pop && q_stat.empty, "pop from empty queue")

endmodule
